// ----- rtl/core/drrip_pkg.sv -----
`default_nettype none
package drrip_pkg;

    // fixed field widths of the ports
    localparam int IN_SET_W  = 11;
    localparam int WAY_FLD_W = 4;
    localparam int ADDR_W    = 16;
    localparam int CFG_W     = 3;
    localparam int STREAK_W  = 3;
    localparam int BIP_W     = 5;

    localparam logic             ACT_QUERY  = 1'b0;
    localparam logic             ACT_UPDATE = 1'b1;
    localparam logic [CFG_W-1:0] LEN_RESET  = 3'd4;
    localparam logic [CFG_W-1:0] LEN_MIN    = 3'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]   last_addr;
        logic [ADDR_W-1:0]   last_stride;
        logic [STREAK_W-1:0] streak;
    } t_stream;

    typedef struct packed {
        logic accept;   // capture transaction and read the set
        logic commit;   // write back and load the result register
        logic clear;    // write one row of the reset sweep
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/core/drrip_replacement_with_stream_bypass_unit.sv -----
// a transaction is accepted by reading its set's recency row and stream state; the
//   write-back and the load of the result register wait until the output is free, and no
//   new transaction is accepted before then, as both rows use single-port memories
// reset: synchronous; a sweep over all SETS rows (2048 by default) fills every recency row
//   with the maximum value and clears the stream state; no transaction is accepted
//   during the sweep, configuration writes are taken
`default_nettype none
module drrip_replacement_with_stream_bypass_unit #(
    parameter int SETS           = 2048,
    parameter int WAYS           = 16,
    parameter int LEADER_SETS    = 32,
    parameter int SELECTOR_WIDTH = 10,
    parameter int RECENCY_WIDTH  = 2
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [drrip_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_action,
    input  wire logic [drrip_pkg::IN_SET_W-1:0]  i_set_index,
    input  wire logic [drrip_pkg::WAY_FLD_W-1:0] i_way,
    input  wire logic [drrip_pkg::ADDR_W-1:0]    i_address_low,
    input  wire logic                            i_hit,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [drrip_pkg::WAY_FLD_W-1:0]      o_victim_way,
    output logic                                 o_streaming_seen,
    output logic                                 o_srrip_in_use
);
    import drrip_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    drrip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    drrip_dp #(
        .SETS           (SETS),
        .WAYS           (WAYS),
        .LEADER_SETS    (LEADER_SETS),
        .SELECTOR_WIDTH (SELECTOR_WIDTH),
        .RECENCY_WIDTH  (RECENCY_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_set_index      (i_set_index),
        .i_way            (i_way),
        .i_address_low    (i_address_low),
        .i_hit            (i_hit),
        .o_victim_way     (o_victim_way),
        .o_streaming_seen (o_streaming_seen),
        .o_srrip_in_use   (o_srrip_in_use)
    );

endmodule
`default_nettype wire

// ----- rtl/core/drrip_ctrl.sv -----
`default_nettype none
module drrip_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output drrip_pkg::t_cmd        o_cmd,
    input  wire drrip_pkg::t_status i_status
);
    import drrip_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit = (r_state == S_EXEC) && out_free;
    assign o_cmd.clear  = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_status.clear_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/drrip_dp.sv -----
`default_nettype none
module drrip_dp #(
    parameter int SETS           = 2048,
    parameter int WAYS           = 16,
    parameter int LEADER_SETS    = 32,
    parameter int SELECTOR_WIDTH = 10,
    parameter int RECENCY_WIDTH  = 2
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire drrip_pkg::t_cmd                 i_cmd,
    output drrip_pkg::t_status                   o_status,
    input  wire logic                            i_cfg_we,
    input  wire logic [drrip_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                            i_action,
    input  wire logic [drrip_pkg::IN_SET_W-1:0]  i_set_index,
    input  wire logic [drrip_pkg::WAY_FLD_W-1:0] i_way,
    input  wire logic [drrip_pkg::ADDR_W-1:0]    i_address_low,
    input  wire logic                            i_hit,
    output logic [drrip_pkg::WAY_FLD_W-1:0]      o_victim_way,
    output logic                                 o_streaming_seen,
    output logic                                 o_srrip_in_use
);
    import drrip_pkg::*;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * RECENCY_WIDTH;
    localparam logic [RECENCY_WIDTH-1:0] RMAX = '1;
    localparam logic [SELECTOR_WIDTH-1:0] SEL_MAX = '1;
    localparam logic [SELECTOR_WIDTH-1:0] SEL_HALF = SEL_MAX >> 1;
    localparam logic [14:0] SETS_MOD = 15'((SETS > 2047) ? 2048 : SETS);
    localparam logic [16:0] LEAD_LO = 17'(LEADER_SETS);
    localparam logic [16:0] LEAD_HI = 17'(2 * LEADER_SETS);
    localparam logic [5:0] WAYS_CNT = 6'(WAYS);
    localparam logic [SET_W-1:0] SET_LAST = SET_W'(SETS - 1);

    // memories, one row per set
    logic [ROW_W-1:0] r_rec_mem [SETS];
    t_stream          r_str_mem [SETS];
    logic [ROW_W-1:0] r_rec_rd;
    t_stream          r_str_rd;

    logic [SET_W-1:0]          r_clr_addr;
    logic [CFG_W-1:0]          r_cfg_len;
    logic [SELECTOR_WIDTH-1:0] r_sel;
    logic [BIP_W-1:0]          r_bip;

    logic                 r_action;
    logic                 r_hit;
    logic [SET_W-1:0]     r_set;
    logic [WAY_FLD_W-1:0] r_way;
    logic [ADDR_W-1:0]    r_addr;

    logic [WAY_FLD_W-1:0] r_victim_way;
    logic                 r_streaming_seen;
    logic                 r_srrip_in_use;

    logic [14:0]        mod_v;
    logic [SET_W-1:0]   set_in;

    // set index reduction by restoring subtraction, quotient is below 16
    always_comb begin
        mod_v = 15'(i_set_index);
        for (int k = 3; k >= 0; k--) begin
            if (mod_v >= (SETS_MOD << k)) begin
                mod_v = mod_v - (SETS_MOD << k);
            end
        end
        set_in = SET_W'(mod_v);
    end

    // stream detector
    logic [CFG_W-1:0]  len;
    logic [ADDR_W-1:0] stride;
    logic              run;
    logic [3:0]        k_inc;
    logic [3:0]        k_sat;
    logic              streaming;
    t_stream           str_new;

    always_comb begin
        len    = (r_cfg_len < LEN_MIN) ? LEN_MIN : r_cfg_len;
        stride = r_addr - r_str_rd.last_addr;
        run    = (r_str_rd.streak != '0) && (stride == r_str_rd.last_stride) && (stride != '0);
        k_inc  = {1'b0, r_str_rd.streak} + 4'd1;
        k_sat  = (k_inc > {1'b0, len}) ? {1'b0, len} : k_inc;
        streaming = run && (k_sat >= {1'b0, len});
        str_new.last_addr   = r_addr;
        str_new.last_stride = run ? r_str_rd.last_stride : stride;
        str_new.streak      = run ? k_sat[STREAK_W-1:0] : STREAK_W'(1);
    end

    // insertion policy of the set
    logic [16:0] set_ext;
    logic        srrip;

    always_comb begin
        set_ext = 17'(r_set);
        priority if (set_ext < LEAD_LO) begin
            srrip = 1'b1;
        end else if (set_ext < LEAD_HI) begin
            srrip = 1'b0;
        end else begin
            srrip = (r_sel >= SEL_HALF);
        end
    end

    // aging: raise the set so its largest value reaches the maximum
    logic [RECENCY_WIDTH-1:0] top;
    logic [RECENCY_WIDTH-1:0] add;
    logic [ROW_W-1:0]         aged_row;
    logic [WAY_IW-1:0]        victim;

    always_comb begin
        top = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_rec_rd[w*RECENCY_WIDTH +: RECENCY_WIDTH] > top) begin
                top = r_rec_rd[w*RECENCY_WIDTH +: RECENCY_WIDTH];
            end
        end
        add = RMAX - top;
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            aged_row[w*RECENCY_WIDTH +: RECENCY_WIDTH] =
                r_rec_rd[w*RECENCY_WIDTH +: RECENCY_WIDTH] + add;
            if (r_rec_rd[w*RECENCY_WIDTH +: RECENCY_WIDTH] == top) begin
                victim = WAY_IW'(w);
            end
        end
    end

    // update of one way
    logic [BIP_W-1:0]         bip_next;
    logic                     bip_fill;
    logic [RECENCY_WIDTH-1:0] ins_val;
    logic                     way_ok;
    logic [ROW_W-1:0]         upd_row;

    always_comb begin
        bip_next = r_bip + BIP_W'(1);
        bip_fill = !r_hit && !streaming && !srrip;
        if (r_hit) begin
            ins_val = '0;
        end else if (streaming || srrip) begin
            ins_val = RMAX;
        end else begin
            ins_val = (bip_next == '0) ? '0 : RMAX;
        end
        way_ok  = 6'(r_way) < WAYS_CNT;
        upd_row = r_rec_rd;
        for (int w = 0; w < WAYS; w++) begin
            if (6'(w) == 6'(r_way)) begin
                upd_row[w*RECENCY_WIDTH +: RECENCY_WIDTH] = ins_val;
            end
        end
    end

    logic             is_upd;
    logic             rec_we;
    logic             str_we;
    logic [SET_W-1:0] wr_addr;
    logic [ROW_W-1:0] rec_wdata;
    t_stream          str_wdata;

    assign is_upd    = (r_action == ACT_UPDATE);
    assign wr_addr   = i_cmd.clear ? r_clr_addr : r_set;
    assign rec_we    = i_cmd.clear || (i_cmd.commit && (!is_upd || way_ok));
    assign str_we    = i_cmd.clear || (i_cmd.commit && is_upd);
    assign rec_wdata = i_cmd.clear ? {WAYS{RMAX}} : (is_upd ? upd_row : aged_row);
    assign str_wdata = i_cmd.clear ? '0 : str_new;
    assign o_status.clear_last = (r_clr_addr == SET_LAST);

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec_mem[wr_addr] <= rec_wdata;
        end
        if (i_cmd.accept) begin
            r_rec_rd <= r_rec_mem[set_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (str_we) begin
            r_str_mem[wr_addr] <= str_wdata;
        end
        if (i_cmd.accept) begin
            r_str_rd <= r_str_mem[set_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_cfg_len  <= LEN_RESET;
            r_sel      <= SEL_HALF;
            r_bip      <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + SET_W'(1);
            end
            if (i_cfg_we) begin
                r_cfg_len <= i_cfg_data;
            end
            if (i_cmd.commit && is_upd) begin
                if (bip_fill) begin
                    r_bip <= bip_next;
                end
                if (!r_hit) begin
                    if (set_ext < LEAD_LO) begin
                        if (r_sel != '0) begin
                            r_sel <= r_sel - SELECTOR_WIDTH'(1);
                        end
                    end else if (set_ext < LEAD_HI) begin
                        if (r_sel != SEL_MAX) begin
                            r_sel <= r_sel + SELECTOR_WIDTH'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_hit    <= i_hit;
            r_set    <= set_in;
            r_way    <= i_way;
            r_addr   <= i_address_low;
        end
        if (i_cmd.commit) begin
            r_victim_way     <= is_upd ? '0 : WAY_FLD_W'(victim);
            r_streaming_seen <= is_upd && streaming;
            r_srrip_in_use   <= srrip;
        end
    end

    assign o_victim_way     = r_victim_way;
    assign o_streaming_seen = r_streaming_seen;
    assign o_srrip_in_use   = r_srrip_in_use;

endmodule
`default_nettype wire

// ----- tb/sv/drrip_replacement_with_stream_bypass_unit_tb.sv -----
`timescale 1ns / 1ps
module drrip_replacement_with_stream_bypass_unit_tb;
    import drrip_pkg::*;

    localparam int SET_COUNT      = 2048;
    localparam int WAY_COUNT      = 16;
    localparam int LEADERS        = 32;
    localparam int SEL_TOP        = 1023;
    localparam logic [1:0] RRV_MAX = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF       = 300;
    localparam int PHASES         = 8;
    localparam logic [CFG_W-1:0] LEN_PLAN [PHASES] =
        '{3'd2, 3'd7, 3'd0, 3'd5, 3'd1, 3'd3, 3'd6, 3'd4};
    // idle modes: none, sender only, receiver only, both (together about a third)
    localparam int TX_IDLE  [4] = '{0, 60, 0, 36};
    localparam int RX_STALL [4] = '{0, 0, 60, 36};

    typedef struct packed {
        logic                 action;
        logic [IN_SET_W-1:0]  set_index;
        logic [WAY_FLD_W-1:0] way;
        logic [ADDR_W-1:0]    address_low;
        logic                 hit;
    } access_t;

    typedef struct packed {
        logic [WAY_FLD_W-1:0] victim_way;
        logic                 streaming_seen;
        logic                 srrip_in_use;
    } outcome_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 i_action      = 1'b0;
    logic [IN_SET_W-1:0]  i_set_index   = '0;
    logic [WAY_FLD_W-1:0] i_way         = '0;
    logic [ADDR_W-1:0]    i_address_low = '0;
    logic                 i_hit         = 1'b0;
    logic                 i_out_stall   = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [WAY_FLD_W-1:0] o_victim_way;
    logic                 o_streaming_seen;
    logic                 o_srrip_in_use;

    // shadow of the replacement state
    logic [1:0]          rrv             [0:SET_COUNT-1][0:WAY_COUNT-1];
    logic [ADDR_W-1:0]   last_addr_mem   [0:SET_COUNT-1];
    logic [ADDR_W-1:0]   last_stride_mem [0:SET_COUNT-1];
    logic [STREAK_W-1:0] streak_mem      [0:SET_COUNT-1];
    logic [9:0]          psel;
    logic [BIP_W-1:0]    bip_count;
    logic [CFG_W-1:0]    detect_len;

    access_t  access_queue[$];
    outcome_t awaited_outcomes[$];
    access_t  offered;
    int       tx_idle_pct  = 0;
    int       rx_stall_pct = 0;
    int       hold_left    = 0;
    int       mismatches   = 0;
    int       idle_cycles  = 0;

    drrip_replacement_with_stream_bypass_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_set_index     (i_set_index),
        .i_way           (i_way),
        .i_address_low   (i_address_low),
        .i_hit           (i_hit),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_victim_way    (o_victim_way),
        .o_streaming_seen(o_streaming_seen),
        .o_srrip_in_use  (o_srrip_in_use)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic set_is_srrip(input int s);
        if (s < LEADERS) return 1'b1;
        if (s < 2 * LEADERS) return 1'b0;
        return psel >= SEL_TOP / 2;
    endfunction

    task automatic predict_access(input access_t acc, output outcome_t res);
        int                s;
        int                len;
        int                k;
        logic [1:0]        top;
        logic [1:0]        fill;
        logic [ADDR_W-1:0] stride;
        logic              streaming;
        logic              srrip;
        s   = int'(acc.set_index);
        res = '0;
        if (acc.action == ACT_QUERY) begin
            // age the set so the oldest way reaches the maximum
            top = 2'd0;
            for (int w = 0; w < WAY_COUNT; w++) if (rrv[s][w] > top) top = rrv[s][w];
            for (int w = 0; w < WAY_COUNT; w++) rrv[s][w] = rrv[s][w] + (RRV_MAX - top);
            for (int w = WAY_COUNT - 1; w >= 0; w--)
                if (rrv[s][w] == RRV_MAX) res.victim_way = WAY_FLD_W'(w);
            res.srrip_in_use = set_is_srrip(s);
        end else begin
            len       = (detect_len < LEN_MIN) ? int'(LEN_MIN) : int'(detect_len);
            stride    = acc.address_low - last_addr_mem[s];
            streaming = 1'b0;
            if (streak_mem[s] != 0 && stride == last_stride_mem[s] && stride != 0) begin
                k = int'(streak_mem[s]) + 1;
                if (k > len) k = len;
                streak_mem[s] = STREAK_W'(k);
                streaming     = (k >= len);
            end else begin
                last_stride_mem[s] = stride;
                streak_mem[s]      = STREAK_W'(1);
            end
            last_addr_mem[s] = acc.address_low;
            srrip = set_is_srrip(s);
            if (acc.hit) begin
                fill = 2'd0;
            end else if (streaming || srrip) begin
                fill = RRV_MAX;
            end else begin
                bip_count = bip_count + 1'b1;
                fill      = (bip_count == 0) ? 2'd0 : RRV_MAX;
            end
            rrv[s][acc.way] = fill;
            if (!acc.hit) begin
                if (s < LEADERS) begin
                    if (psel != 0) psel = psel - 1'b1;
                end else if (s < 2 * LEADERS) begin
                    if (psel != SEL_TOP) psel = psel + 1'b1;
                end
            end
            res.streaming_seen = streaming;
            res.srrip_in_use   = srrip;
        end
    endtask

    task automatic queue_access(input logic act, input int s, input int w, input int a,
                                input logic h);
        access_t t;
        t.action      = act;
        t.set_index   = IN_SET_W'(s);
        t.way         = WAY_FLD_W'(w);
        t.address_low = ADDR_W'(a);
        t.hit         = h;
        access_queue = {access_queue, t};
    endtask

    // run of updates on one set with a constant stride, sometimes broken, with queries mixed in
    task automatic queue_stream(input int s, input int len, input int hit_pct,
                                input int query_pct);
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] step;
        a = ADDR_W'($urandom);
        case ($urandom_range(3))
            0: step = 16'h0001;
            1: step = 16'h0040;
            2: step = 16'hffc0;
            default: step = ADDR_W'($urandom);
        endcase
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(99) < 6) a = ADDR_W'($urandom);
            queue_access(ACT_UPDATE, s, $urandom_range(15), int'(a),
                         $urandom_range(99) < hit_pct);
            if ($urandom_range(99) < query_pct)
                queue_access(ACT_QUERY, s, $urandom_range(15), $urandom,
                             1'($urandom_range(1)));
            a = a + step;
        end
    endtask

    function automatic int pick_set(input bit brrip_lean);
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            if (brrip_lean && $urandom_range(3) != 0)
                return $urandom_range(2 * LEADERS - 1, LEADERS);
            return $urandom_range(2 * LEADERS - 1);
        end
        if (r < 80) return $urandom_range(2 * LEADERS + 7, 2 * LEADERS);
        return $urandom_range(SET_COUNT - 1);
    endfunction

    task automatic queue_random_traffic(input int count, input bit brrip_lean);
        int start;
        int pick;
        start = access_queue.size();
        while (access_queue.size() - start < count) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                queue_stream(pick_set(brrip_lean), $urandom_range(9, 2), 30, 20);
            end else if (pick < 85) begin
                queue_access(ACT_QUERY, pick_set(brrip_lean), $urandom_range(15), $urandom,
                             1'($urandom_range(1)));
            end else begin
                queue_access(1'($urandom_range(1)), $urandom_range(SET_COUNT - 1),
                             $urandom_range(15), $urandom, 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic write_detect_len(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        detect_len = v;
    endtask

    // driver
    always @(posedge i_clk) begin
        outcome_t predicted;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_access(offered, predicted);
                awaited_outcomes = {awaited_outcomes, predicted};
            end
            if (!i_in_valid || !o_in_stall) begin
                if (access_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    offered = access_queue.pop_front();
                    i_in_valid    <= 1'b1;
                    i_action      <= offered.action;
                    i_set_index   <= offered.set_index;
                    i_way         <= offered.way;
                    i_address_low <= offered.address_low;
                    i_hit         <= offered.hit;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        outcome_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("unexpected transaction: victim_way %0d streaming_seen %0b",
                           o_victim_way, o_streaming_seen);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (o_victim_way !== want.victim_way) begin
                        $error("victim_way: expected %0d, got %0d",
                               want.victim_way, o_victim_way);
                        mismatches++;
                    end
                    if (o_streaming_seen !== want.streaming_seen) begin
                        $error("streaming_seen: expected %0b, got %0b",
                               want.streaming_seen, o_streaming_seen);
                        mismatches++;
                    end
                    if (o_srrip_in_use !== want.srrip_in_use) begin
                        $error("srrip_in_use: expected %0b, got %0b",
                               want.srrip_in_use, o_srrip_in_use);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int misses;
        for (int s = 0; s < SET_COUNT; s++) begin
            for (int w = 0; w < WAY_COUNT; w++) rrv[s][w] = RRV_MAX;
            last_addr_mem[s]   = '0;
            last_stride_mem[s] = '0;
            streak_mem[s]      = '0;
        end
        psel       = 10'(SEL_TOP / 2);
        bip_count  = '0;
        detect_len = LEN_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            write_detect_len(LEN_PLAN[p]);
            @(negedge i_clk);
            tx_idle_pct  = TX_IDLE[p % 4];
            rx_stall_pct = RX_STALL[p % 4];
            case (p)
                0: begin
                    // all ways at max after reset, query flag ignored
                    queue_access(ACT_QUERY, 0, 0, 0, 1'b0);
                    queue_access(ACT_QUERY, SET_COUNT - 1, 15, 16'hffff, 1'b1);
                    queue_access(ACT_UPDATE, 5, 0, 16'h0000, 1'b1);
                    queue_access(ACT_UPDATE, 5, 15, 16'hffff, 1'b1);
                    // zero stride restarts the streak
                    queue_access(ACT_UPDATE, 5, 7, 16'hffff, 1'b0);
                    queue_access(ACT_QUERY, 5, 0, 0, 1'b0);
                    // stride through the top of the address range
                    queue_access(ACT_UPDATE, 100, 1, 16'hffe0, 1'b0);
                    queue_access(ACT_UPDATE, 100, 2, 16'hfff0, 1'b0);
                    queue_access(ACT_UPDATE, 100, 3, 16'h0000, 1'b0);
                    queue_access(ACT_UPDATE, 100, 4, 16'h0010, 1'b0);
                    queue_access(ACT_UPDATE, 100, 5, 16'h0020, 1'b0);
                    queue_access(ACT_UPDATE, 100, 6, 16'h0020, 1'b0);
                    queue_access(ACT_QUERY, 100, 0, 0, 1'b0);
                    // leader set boundaries
                    queue_access(ACT_UPDATE, 0, 0, 16'h1234, 1'b0);
                    queue_access(ACT_UPDATE, LEADERS - 1, 3, 16'h0001, 1'b0);
                    queue_access(ACT_UPDATE, LEADERS, 9, 16'h8000, 1'b0);
                    queue_access(ACT_UPDATE, 2 * LEADERS - 1, 15, 16'h7fff, 1'b0);
                    queue_access(ACT_UPDATE, 2 * LEADERS, 8, 16'h5555, 1'b0);
                    queue_access(ACT_UPDATE, 2 * LEADERS - 1, 15, 16'haaaa, 1'b1);
                    queue_access(ACT_QUERY, 2 * LEADERS - 1, 0, 0, 1'b0);
                    queue_access(ACT_UPDATE, SET_COUNT - 1, 15, 16'hffff, 1'b0);
                    queue_access(ACT_QUERY, SET_COUNT - 1, 0, 0, 1'b0);
                    queue_access(ACT_QUERY, 1024, 0, 0, 1'b0);
                end
                5: begin
                    // miss runs in the srrip leaders until the selector pins at zero
                    misses = 0;
                    while (misses < psel + 40) begin
                        k_len_stream: begin
                            int len;
                            len = $urandom_range(8, 2);
                            queue_stream($urandom_range(LEADERS - 1), len, 0, 10);
                            misses += len;
                        end
                    end
                end
                default: begin
                    // random traffic; phase 4 fills the block behind a long receiver hold-off
                    if (p == 4) hold_left = HOLD_OFF;
                    queue_random_traffic(140, p >= 6);
                end
            endcase
            do @(negedge i_clk);
            while (access_queue.size() != 0 || i_in_valid || awaited_outcomes.size() != 0);
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && awaited_outcomes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
